// ----- src/csvfs_pkg.sv -----
// csvfs_pkg: shared types and constants of the CSV field splitter.
// Used by every module under src.
// No dependencies.
package csvfs_pkg;

  // Special bytes of the text stream
  localparam logic [7:0] QUOTE_BYTE   = 8'd34;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] DELIM_RESET  = 8'd44;

  // Runs in the queue between front and back, and words per run
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
  localparam int unsigned RUN_MAX = 3;
  localparam int unsigned RIDX_W  = $clog2(RUN_MAX);

  // Result word kinds
  typedef enum logic [1:0] {
    KIND_CHAR       = 2'd0,
    KIND_END_FIELD  = 2'd1,
    KIND_END_RECORD = 2'd2
  } kind_e;

  // One result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } result_t;

  // All result words caused by one input byte
  typedef struct packed {
    logic [RIDX_W-1:0]          count;  // 1..RUN_MAX when queued
    result_t [RUN_MAX-1:0]      res;
  } run_t;

  // Front to queue
  typedef struct packed {
    logic push;
    run_t run;
  } push_t;

  // Queue status seen by the front and by checks
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

// ----- src/csvfs_if.sv -----
// csvfs_if: valid/ready channel interfaces of the CSV field splitter.
// Byte channel in, result channel out. No dependencies.
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface csvfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, output kind, output char_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input char_out, input last_of_run,
                  output ready);
endinterface

// ----- src/csvfs_front.sv -----
// csvfs_front: accepts text bytes, tracks the parse mode and turns each byte
// into a run of up to three result words. Depends on csvfs_pkg.
module csvfs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  delim_we_i,
  input  logic [7:0]            delim_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_char_i,
  output logic                  in_ready_o,
  input  csvfs_pkg::qstat_t     qstat_i,
  output csvfs_pkg::push_t      push_o
);

  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_UNQ       = 3'd1,
    MODE_UNQ_QUOTE = 3'd2,
    MODE_QUO       = 3'd3,
    MODE_QUO_QUOTE = 3'd4,
    MODE_SKIP      = 3'd5
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       content_q, content_d;
  logic [7:0] delim_q;

  logic       accept;
  logic       is_nl, is_quote, is_delim;
  logic       emit_quote, emit_char, emit_ef, emit_er;
  logic [csvfs_pkg::RIDX_W-1:0] n;
  csvfs_pkg::run_t run;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign is_nl    = (in_char_i == csvfs_pkg::NEWLINE_BYTE);
  assign is_quote = (in_char_i == csvfs_pkg::QUOTE_BYTE);
  assign is_delim = (in_char_i == delim_q) && !is_nl && !is_quote;

  // Next mode and which words this byte causes
  always_comb begin
    mode_d     = mode_q;
    content_d  = content_q;
    emit_quote = 1'b0;
    emit_char  = 1'b0;
    emit_ef    = 1'b0;
    emit_er    = 1'b0;
    case (mode_q)
      MODE_UNQ, MODE_UNQ_QUOTE: begin
        // pending lone quote is a literal
        emit_quote = (mode_q == MODE_UNQ_QUOTE);
        if (mode_q == MODE_UNQ_QUOTE && is_quote) begin
          mode_d = MODE_UNQ;
        end else if (is_nl) begin
          emit_ef   = 1'b1;
          emit_er   = 1'b1;
          mode_d    = MODE_START;
          content_d = 1'b0;
        end else if (is_quote) begin
          mode_d = MODE_UNQ_QUOTE;
        end else if (is_delim) begin
          emit_ef = 1'b1;
          mode_d  = MODE_START;
        end else begin
          emit_char = 1'b1;
          mode_d    = MODE_UNQ;
        end
      end
      MODE_QUO: begin
        if (is_nl) begin
          emit_ef   = 1'b1;
          emit_er   = 1'b1;
          mode_d    = MODE_START;
          content_d = 1'b0;
        end else if (is_quote) begin
          mode_d = MODE_QUO_QUOTE;
        end else begin
          emit_char = 1'b1;
        end
      end
      MODE_QUO_QUOTE: begin
        if (is_quote) begin
          emit_quote = 1'b1;
          mode_d     = MODE_QUO;
        end else if (is_nl) begin
          emit_ef   = 1'b1;
          emit_er   = 1'b1;
          mode_d    = MODE_START;
          content_d = 1'b0;
        end else if (is_delim) begin
          emit_ef = 1'b1;
          mode_d  = MODE_START;
        end else begin
          // bad closing quote: drop rest of line
          emit_ef = 1'b1;
          mode_d  = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (is_nl) begin
          emit_er   = 1'b1;
          mode_d    = MODE_START;
          content_d = 1'b0;
        end
      end
      default: begin
        if (is_nl) begin
          // empty line gives no record
          emit_ef   = content_q;
          emit_er   = content_q;
          mode_d    = MODE_START;
          content_d = 1'b0;
        end else begin
          content_d = 1'b1;
          if (is_quote) begin
            mode_d = MODE_QUO;
          end else if (is_delim) begin
            emit_ef = 1'b1;
            mode_d  = MODE_START;
          end else begin
            emit_char = 1'b1;
            mode_d    = MODE_UNQ;
          end
        end
      end
    endcase
  end

  // Pack words in order: quote literal, char or end of field, end of record
  always_comb begin
    run = '0;
    n   = '0;
    if (emit_quote) begin
      run.res[n] = '{kind: csvfs_pkg::KIND_CHAR, ch: csvfs_pkg::QUOTE_BYTE};
      n = n + 1'b1;
    end
    if (emit_char) begin
      run.res[n] = '{kind: csvfs_pkg::KIND_CHAR, ch: in_char_i};
      n = n + 1'b1;
    end
    if (emit_ef) begin
      run.res[n] = '{kind: csvfs_pkg::KIND_END_FIELD, ch: 8'd0};
      n = n + 1'b1;
    end
    if (emit_er) begin
      run.res[n] = '{kind: csvfs_pkg::KIND_END_RECORD, ch: 8'd0};
      n = n + 1'b1;
    end
    run.count = n;
  end

  assign push_o.push = accept && (n != '0);
  assign push_o.run  = run;

  // Parse state and delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      content_q <= 1'b0;
      delim_q   <= csvfs_pkg::DELIM_RESET;
    end else begin
      if (delim_we_i) begin
        delim_q <= delim_i;
      end
      if (accept) begin
        mode_q    <= mode_d;
        content_q <= content_d;
      end
    end
  end

endmodule

// ----- src/csvfs_queue.sv -----
// csvfs_queue: short FIFO of runs between front and back.
// Depends on csvfs_pkg.
module csvfs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csvfs_pkg::push_t      push_i,
  input  logic                  pop_i,
  output csvfs_pkg::run_t       head_o,
  output csvfs_pkg::qstat_t     qstat_o
);

  csvfs_pkg::run_t mem_q [csvfs_pkg::QDEPTH];

  logic [csvfs_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [csvfs_pkg::QCNT_W-1:0] cnt_q;
  logic                         do_push, do_pop;

  assign qstat_o.full  = (cnt_q == csvfs_pkg::QCNT_W'(csvfs_pkg::QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.count = cnt_q;

  assign do_push = push_i.push && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.run;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/csvfs_back.sv -----
// csvfs_back: walks the head run word by word into the output register.
// Depends on csvfs_pkg.
module csvfs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csvfs_pkg::run_t       head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_kind_o,
  output logic [7:0]            out_char_o,
  output logic                  out_last_o
);

  logic [csvfs_pkg::RIDX_W-1:0] idx_q;
  logic                         valid_q;
  csvfs_pkg::result_t           word_q;
  logic                         last_q;
  logic                         load, is_last;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.count - 1'b1);
  assign pop_o   = load && is_last;

  assign out_valid_o = valid_q;
  assign out_kind_o  = word_q.kind;
  assign out_char_o  = word_q.ch;
  assign out_last_o  = last_q;

  // Word index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= head_i.res[idx_q];
      last_q <= is_last;
    end
  end

endmodule

// ----- src/csv_field_splitter.sv -----
// csv_field_splitter: top level of the byte-serial CSV field splitter.
// Depends on csvfs_pkg, csvfs_if, csvfs_front, csvfs_queue and csvfs_back.
//
//   channel     dir  handshake      payload
//   in_ch       in   valid/ready    char_in[7:0]
//   out_ch      out  valid/ready    kind[1:0], char_out[7:0], last_of_run
//   delimiter   in   delimiter_we_i delimiter_i[7:0]
//
// A byte is taken every cycle while the four-run queue has room; it is
// classified in the cycle it is taken. The output register sends one word
// per cycle while runs are queued and the receiver is ready; the words of
// a byte pass through the queue and then the output register. Reset clears
// parse mode, queue and output valid and sets the delimiter to a comma.
// Either side may stall; the queue absorbs up to four runs before input
// ready drops.
module csv_field_splitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               delimiter_we_i,
  input  logic [7:0]         delimiter_i,
  csvfs_in_if.sink           in_ch,
  csvfs_out_if.source        out_ch
);

  csvfs_pkg::push_t  push;
  csvfs_pkg::qstat_t qstat;
  csvfs_pkg::run_t   head;
  logic              pop;

  csvfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .delim_we_i (delimiter_we_i),
    .delim_i    (delimiter_i),
    .in_valid_i (in_ch.valid),
    .in_char_i  (in_ch.char_in),
    .in_ready_o (in_ch.ready),
    .qstat_i    (qstat),
    .push_o     (push)
  );

  csvfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  csvfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!qstat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_kind_o   (out_ch.kind),
    .out_char_o   (out_ch.char_out),
    .out_last_o   (out_ch.last_of_run)
  );

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> !qstat.full)
    else $error("run pushed into full queue");

  // Fill count stays within depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= csvfs_pkg::QCNT_W'(csvfs_pkg::QDEPTH))
    else $error("queue count out of range");

  // End of record always closes the run of its byte
  a_er_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.kind == csvfs_pkg::KIND_END_RECORD)
      |-> out_ch.last_of_run)
    else $error("end of record not last of run");

  // Markers carry a zero character
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.kind != csvfs_pkg::KIND_CHAR) |-> out_ch.char_out == 8'd0)
    else $error("marker word with nonzero character");

  // Queued runs are never empty
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat.empty |-> head.count != '0)
    else $error("empty run in queue");

endmodule

// ----- sim/tb_csv_field_splitter.sv -----
// tb_csv_field_splitter: self-checking bench for the byte-serial CSV field splitter.
// Drives text bytes and delimiter settings, predicts every result word and checks it.
// Depends on csvfs_pkg, csvfs_if and csv_field_splitter under src.
module tb_csv_field_splitter;

  localparam logic [7:0] CR_BYTE     = 8'd13;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 38;   // minimum bytes per delimiter setting
  localparam int unsigned HOLD_PHASE = 1;
  localparam int unsigned CALM_PHASE = 5;
  localparam int unsigned HOLD_LEN   = 40;   // long output back-pressure
  localparam int unsigned SETTLE     = 8;    // covers bytes still in flight
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS = 50;

  // Parser position, mirrors the block's parse mode
  typedef enum logic [2:0] {
    PM_START, PM_UNQ, PM_UNQ_QUOTE, PM_QUO, PM_QUO_QUOTE, PM_SKIP
  } pmode_e;

  // One output word as seen on the result channel
  typedef struct packed {
    csvfs_pkg::kind_e kind;
    logic [7:0]       ch;
    logic             last;
  } word_t;

  // Directed stimulus row; words are used only when typed is set
  typedef struct packed {
    logic [7:0]      b;
    logic            typed;
    logic [1:0]      n;
    word_t [0:2]     w;
  } row_t;

  localparam word_t NO_WORD = '{csvfs_pkg::KIND_CHAR, 8'h00, 1'b0};
  localparam word_t EF_MID  = '{csvfs_pkg::KIND_END_FIELD, 8'h00, 1'b0};
  localparam word_t EF_LAST = '{csvfs_pkg::KIND_END_FIELD, 8'h00, 1'b1};
  localparam word_t ER_LAST = '{csvfs_pkg::KIND_END_RECORD, 8'h00, 1'b1};
  localparam row_t  UNTYPED = '{8'h00, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}};

  logic       clk_i;
  logic       rst_ni;
  logic       delimiter_we_i;
  logic [7:0] delimiter_i;

  csvfs_in_if  in_ch ();
  csvfs_out_if out_ch ();

  csv_field_splitter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .delimiter_we_i (delimiter_we_i),
    .delimiter_i    (delimiter_i),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );

  // Directed text: empty line, extremes, quote handling, discard, CR, open quote
  row_t dir_rows [25] = '{
    '{csvfs_pkg::NEWLINE_BYTE, 1'b1, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},  // empty line
    '{8'h61, 1'b1, 2'd1, '{'{csvfs_pkg::KIND_CHAR, 8'h61, 1'b1}, NO_WORD, NO_WORD}},
    '{8'hFF, 1'b1, 2'd1, '{'{csvfs_pkg::KIND_CHAR, 8'hFF, 1'b1}, NO_WORD, NO_WORD}},
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},    // lone quote
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},    // doubled
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::NEWLINE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},  // three words
    '{8'h00, 1'b1, 2'd1, '{'{csvfs_pkg::KIND_CHAR, 8'h00, 1'b1}, NO_WORD, NO_WORD}},
    '{csvfs_pkg::DELIM_RESET, 1'b1, 2'd1, '{EF_LAST, NO_WORD, NO_WORD}},
    '{csvfs_pkg::NEWLINE_BYTE, 1'b1, 2'd2, '{EF_MID, ER_LAST, NO_WORD}},   // trailing delim
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},    // quoted field
    '{8'h78, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::DELIM_RESET, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},    // empty quoted
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{8'h7A, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},                    // junk after quote
    '{8'h71, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::NEWLINE_BYTE, 1'b1, 2'd1, '{ER_LAST, NO_WORD, NO_WORD}},  // record only
    '{csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{CR_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},
    '{csvfs_pkg::NEWLINE_BYTE, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}},  // open quote
    '{csvfs_pkg::DELIM_RESET, 1'b0, 2'd0, '{NO_WORD, NO_WORD, NO_WORD}}
  };

  // Predictor state
  pmode_e     mode;
  logic       line_open;
  logic [7:0] cur_delim;
  word_t      run_words[$];
  word_t      expected_words[$];
  logic [7:0] text_q[$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  bit          in_calm;
  bit          out_calm;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void emit(csvfs_pkg::kind_e k, logic [7:0] ch);
    run_words.push_back(word_t'{k, ch, 1'b0});
  endfunction

  function automatic void close_line(logic with_field);
    if (with_field) emit(csvfs_pkg::KIND_END_FIELD, 8'h00);
    emit(csvfs_pkg::KIND_END_RECORD, 8'h00);
    mode      = PM_START;
    line_open = 1'b0;
  endfunction

  // Words caused by one byte land in run_words, last flag on the final one
  function automatic void split_byte(logic [7:0] c);
    logic as_unquoted;
    run_words.delete();
    as_unquoted = (mode == PM_UNQ);
    case (mode)
      PM_UNQ: ;
      PM_UNQ_QUOTE: begin
        // pending lone quote is kept literally
        emit(csvfs_pkg::KIND_CHAR, csvfs_pkg::QUOTE_BYTE);
        if (c == csvfs_pkg::QUOTE_BYTE) mode = PM_UNQ;
        else as_unquoted = 1'b1;
      end
      PM_QUO: begin
        if (c == csvfs_pkg::NEWLINE_BYTE) close_line(1'b1);
        else if (c == csvfs_pkg::QUOTE_BYTE) mode = PM_QUO_QUOTE;
        else emit(csvfs_pkg::KIND_CHAR, c);
      end
      PM_QUO_QUOTE: begin
        if (c == csvfs_pkg::QUOTE_BYTE) begin
          emit(csvfs_pkg::KIND_CHAR, csvfs_pkg::QUOTE_BYTE);
          mode = PM_QUO;
        end else if (c == csvfs_pkg::NEWLINE_BYTE) begin
          close_line(1'b1);
        end else if (c == cur_delim) begin
          emit(csvfs_pkg::KIND_END_FIELD, 8'h00);
          mode = PM_START;
        end else begin
          // bad byte after closing quote: drop rest of line
          emit(csvfs_pkg::KIND_END_FIELD, 8'h00);
          mode = PM_SKIP;
        end
      end
      PM_SKIP: begin
        if (c == csvfs_pkg::NEWLINE_BYTE) close_line(1'b0);
      end
      default: begin
        if (c == csvfs_pkg::NEWLINE_BYTE) begin
          if (line_open) close_line(1'b1);
          mode      = PM_START;
          line_open = 1'b0;
        end else begin
          line_open = 1'b1;
          if (c == csvfs_pkg::QUOTE_BYTE) begin
            mode = PM_QUO;
          end else if (c == cur_delim) begin
            emit(csvfs_pkg::KIND_END_FIELD, 8'h00);
            mode = PM_START;
          end else begin
            emit(csvfs_pkg::KIND_CHAR, c);
            mode = PM_UNQ;
          end
        end
      end
    endcase
    if (as_unquoted) begin
      if (c == csvfs_pkg::NEWLINE_BYTE) begin
        close_line(1'b1);
      end else if (c == csvfs_pkg::QUOTE_BYTE) begin
        mode = PM_UNQ_QUOTE;
      end else if (c == cur_delim) begin
        emit(csvfs_pkg::KIND_END_FIELD, 8'h00);
        mode = PM_START;
      end else begin
        emit(csvfs_pkg::KIND_CHAR, c);
        mode = PM_UNQ;
      end
    end
    if (run_words.size() != 0) run_words[run_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- text generation
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == csvfs_pkg::NEWLINE_BYTE || b == csvfs_pkg::QUOTE_BYTE || b == cur_delim);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return csvfs_pkg::NEWLINE_BYTE;
      1:       return csvfs_pkg::QUOTE_BYTE;
      2:       return cur_delim;
      3:       return CR_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed records; some empty lines, noise and broken endings
  task automatic queue_record();
    int unsigned style;
    int unsigned nf;
    int unsigned len;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      text_q.push_back(csvfs_pkg::NEWLINE_BYTE);
    end else if (style <= 2) begin
      len = $urandom_range(1, 8);
      repeat (len) text_q.push_back(noise_byte());
    end else begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) text_q.push_back(cur_delim);
        len = $urandom_range(0, 4);
        if ($urandom_range(0, 1) == 1) begin
          // quoted field, may hold delimiters and doubled quotes
          text_q.push_back(csvfs_pkg::QUOTE_BYTE);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: begin
                text_q.push_back(csvfs_pkg::QUOTE_BYTE);
                text_q.push_back(csvfs_pkg::QUOTE_BYTE);
              end
              1:       text_q.push_back(cur_delim);
              default: text_q.push_back(data_byte());
            endcase
          end
          if ($urandom_range(0, 9) != 0) text_q.push_back(csvfs_pkg::QUOTE_BYTE);
        end else begin
          // unquoted field with the odd lone or doubled quote
          repeat (len) begin
            case ($urandom_range(0, 7))
              0: begin
                text_q.push_back(csvfs_pkg::QUOTE_BYTE);
                text_q.push_back(csvfs_pkg::QUOTE_BYTE);
              end
              1:       text_q.push_back(csvfs_pkg::QUOTE_BYTE);
              default: text_q.push_back(data_byte());
            endcase
          end
        end
      end
      if ($urandom_range(0, 7) == 0) text_q.push_back(data_byte());
      text_q.push_back(csvfs_pkg::NEWLINE_BYTE);
    end
  endtask

  // ---------------------------------------------------------------- input side
  task automatic send_byte(input row_t r);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= r.b;
    do @(posedge clk_i); while (!in_ch.ready);
    split_byte(r.b);
    if (r.typed) begin
      for (int k = 0; k < r.n; k++) expected_words.push_back(r.w[k]);
    end else begin
      foreach (run_words[k]) expected_words.push_back(run_words[k]);
    end
    bytes_sent++;
  endtask

  // Stop offering bytes and wait until the block has gone quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- output side
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_word();
    word_t exp_w;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind %0d char %0d last %0d",
                                out_ch.kind, out_ch.char_out, out_ch.last_of_run));
      return;
    end
    exp_w = expected_words[0];
    expected_words.delete(0);
    if (out_ch.kind !== exp_w.kind)
      report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, exp_w.kind));
    if (out_ch.char_out !== exp_w.ch)
      report_mismatch($sformatf("char_out %0d, want %0d", out_ch.char_out, exp_w.ch));
    if (out_ch.last_of_run !== exp_w.last)
      report_mismatch($sformatf("last_of_run %0d, want %0d", out_ch.last_of_run, exp_w.last));
  endtask

  // Receiver: random stalls per word, one long hold-off on request
  initial begin
    int unsigned pause;
    forever begin
      if (hold_req) begin
        pause    = HOLD_LEN;
        hold_req = 1'b0;
      end else begin
        pause = out_calm ? 0 : $urandom_range(0, 4);
      end
      if (pause != 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      check_word();
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    logic [7:0]  delim_plan [PHASES];
    int unsigned target;
    row_t        r;
    mismatches     = 0;
    bytes_sent     = 0;
    idle_cycles    = 0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    hold_req       = 1'b0;
    mode           = PM_START;
    line_open      = 1'b0;
    cur_delim      = csvfs_pkg::DELIM_RESET;
    delim_plan     = '{8'h00, 8'hFF, csvfs_pkg::NEWLINE_BYTE, csvfs_pkg::QUOTE_BYTE, 8'h09,
                       8'h3B, 8'h00, csvfs_pkg::DELIM_RESET};
    delim_plan[6]  = 8'($urandom_range(0, 255));
    rst_ni         <= 1'b0;
    delimiter_we_i <= 1'b0;
    delimiter_i    <= csvfs_pkg::DELIM_RESET;
    in_ch.valid    <= 1'b0;
    in_ch.char_in  <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text with the reset delimiter
    foreach (dir_rows[i]) send_byte(dir_rows[i]);

    // one random phase per delimiter setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      delimiter_we_i <= 1'b1;
      delimiter_i    <= delim_plan[p];
      @(posedge clk_i);
      delimiter_we_i <= 1'b0;
      cur_delim      = delim_plan[p];
      in_calm        = (p == HOLD_PHASE) || (p == CALM_PHASE) || ($urandom_range(0, 3) == 0);
      out_calm       = (p == CALM_PHASE) || ($urandom_range(0, 3) == 0);
      hold_req       = (p == HOLD_PHASE);
      target         = bytes_sent + PHASE_LEN;
      while (bytes_sent < target) begin
        queue_record();
        while (text_q.size() != 0) begin
          r   = UNTYPED;
          r.b = text_q[0];
          text_q.delete(0);
          send_byte(r);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/csvfs_pkg.sv
src/csvfs_if.sv
src/csvfs_front.sv
src/csvfs_queue.sv
src/csvfs_back.sv
src/csv_field_splitter.sv
sim/tb_csv_field_splitter.sv
